// ----- sv/hrbp_pkg.sv -----
// ---------------------------------------------------------------------------
// HTTP request byte parser package
// Shared types, character codes and the fixed word tables used for matching.
// ---------------------------------------------------------------------------
`default_nettype none

package hrbp_pkg;

   // parse phase, one-hot
   typedef enum logic [4:0] {
      PH_LINE = 5'b00001,
      PH_HEAD = 5'b00010,
      PH_BODY = 5'b00100,
      PH_DONE = 5'b01000,
      PH_ERR  = 5'b10000
   } phase_type;

   // request line step, one-hot
   typedef enum logic [3:0] {
      LS_METHOD  = 4'b0001,
      LS_URL     = 4'b0010,
      LS_VERSION = 4'b0100,
      LS_LF      = 4'b1000
   } line_type;

   // header line step, one-hot
   typedef enum logic [6:0] {
      HS_KEY       = 7'b0000001,
      HS_COLON     = 7'b0000010,
      HS_VAL_FIRST = 7'b0000100,
      HS_VAL       = 7'b0001000,
      HS_CR        = 7'b0010000,
      HS_NEXT      = 7'b0100000,
      HS_END       = 7'b1000000
   } head_type;

   // Content-Length digit scan, one-hot
   typedef enum logic [3:0] {
      DG_NONE   = 4'b0001,
      DG_DIGITS = 4'b0010,
      DG_DONE   = 4'b0100,
      DG_BAD    = 4'b1000
   } digit_type;

   typedef enum logic [1:0] {
      WL_METHOD,
      WL_VERSION,
      WL_KEY,
      WL_VALUE
   } word_list_type;

   typedef struct packed {
      word_list_type list;
      logic          fresh;   // match against a freshly started word
   } match_ctl_type;

   typedef struct packed {
      logic [11:0] cand;
      logic [3:0]  pos;
      logic [3:0]  code;      // end-of-word code for the state before this byte
   } match_res_type;

   typedef struct packed {
      logic [7:0] byte_echo;
      logic [2:0] token_kind;
      logic [2:0] parse_phase;
      logic [3:0] method_code;
      logic [1:0] version_code;
      logic       keep_alive;
      logic       section_end;
   } result_type;

   localparam logic [11:0] CAND_ALL = 12'hFFF;
   localparam logic [3:0]  POS_MAX  = 4'd15;

   localparam logic [2:0] TOK_NONE    = 3'd0;
   localparam logic [2:0] TOK_METHOD  = 3'd1;
   localparam logic [2:0] TOK_URL     = 3'd2;
   localparam logic [2:0] TOK_VERSION = 3'd3;
   localparam logic [2:0] TOK_KEY     = 3'd4;
   localparam logic [2:0] TOK_VALUE   = 3'd5;
   localparam logic [2:0] TOK_BODY    = 3'd6;

   localparam logic [2:0] PCODE_LINE = 3'd0;
   localparam logic [2:0] PCODE_HEAD = 3'd1;
   localparam logic [2:0] PCODE_BODY = 3'd2;
   localparam logic [2:0] PCODE_DONE = 3'd3;
   localparam logic [2:0] PCODE_ERR  = 3'd4;

   localparam logic [1:0] KEY_NONE = 2'd0;
   localparam logic [1:0] KEY_CLEN = 2'd1;
   localparam logic [1:0] KEY_CONN = 2'd2;

   localparam logic [3:0] VER_11     = 4'd2;
   localparam logic [3:0] VAL_KEEP   = 4'd1;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] c;
      case (ph)
         PH_LINE: c = PCODE_LINE;
         PH_HEAD: c = PCODE_HEAD;
         PH_BODY: c = PCODE_BODY;
         PH_DONE: c = PCODE_DONE;
         default: c = PCODE_ERR;
      endcase
      return c;
   endfunction

   // word text, right-aligned: first character in the highest used byte
   function automatic logic [127:0] word_text(input logic [3:0] k);
      logic [127:0] w;
      case (k)
         4'd0:    w = "GET";
         4'd1:    w = "POST";
         4'd2:    w = "HEAD";
         4'd3:    w = "PUT";
         4'd4:    w = "DELETE";
         4'd5:    w = "CONNECT";
         4'd6:    w = "OPTIONS";
         4'd7:    w = "TRACE";
         4'd8:    w = "PATCH";
         4'd9:    w = "HTTP/1.0";
         4'd10:   w = "HTTP/1.1";
         4'd11:   w = "content-length";
         4'd12:   w = "connection";
         4'd13:   w = "keep-alive";
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] word_len(input logic [3:0] k);
      logic [3:0] n;
      case (k)
         4'd0, 4'd3:                n = 4'd3;
         4'd1, 4'd2:                n = 4'd4;
         4'd4:                      n = 4'd6;
         4'd5, 4'd6:                n = 4'd7;
         4'd7, 4'd8:                n = 4'd5;
         4'd9, 4'd10:               n = 4'd8;
         4'd11:                     n = 4'd14;
         4'd12, 4'd13:              n = 4'd10;
         default:                   n = 4'd0;
      endcase
      return n;
   endfunction

   // character at position p; caller guarantees p < word_len(k)
   function automatic logic [7:0] word_char(input logic [3:0] k, input logic [3:0] p);
      logic [127:0] w;
      logic [3:0]   idx;
      w   = word_text(k);
      idx = word_len(k) - 4'd1 - p;
      return w[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ----- sv/hrbp_word_match.sv -----
// ---------------------------------------------------------------------------
// HTTP request byte parser word matcher
// Narrows the live candidate set of one word list by one byte.
// ---------------------------------------------------------------------------
`default_nettype none

module hrbp_word_match
   import hrbp_pkg::*;
(
   input  match_ctl_type ctl,
   input  logic [11:0]   cand,
   input  logic [3:0]    pos,
   input  logic [7:0]    data_byte,
   output match_res_type res
);

   logic [3:0]  base;
   logic [3:0]  count;
   logic        fold_en;
   logic [11:0] cand_src;
   logic [3:0]  pos_src;
   logic [7:0]  b;

   always_comb begin
      case (ctl.list)
         WL_METHOD:  begin base = 4'd0;  count = 4'd9; fold_en = 1'b0; end
         WL_VERSION: begin base = 4'd9;  count = 4'd2; fold_en = 1'b0; end
         WL_KEY:     begin base = 4'd11; count = 4'd2; fold_en = 1'b1; end
         default:    begin base = 4'd13; count = 4'd1; fold_en = 1'b1; end
      endcase
   end

   assign cand_src = ctl.fresh ? CAND_ALL : cand;
   assign pos_src  = ctl.fresh ? 4'd0 : pos;
   assign b = (fold_en && data_byte >= CH_UA && data_byte <= CH_UZ) ?
              data_byte + 8'd32 : data_byte;

   always_comb begin
      res.cand = cand_src;
      res.code = 4'd0;
      // drop candidates that run out or differ at this position
      for (int i = 0; i < 12; i++) begin
         if (4'(i) < count && cand_src[i]) begin
            if (pos_src >= word_len(base + 4'(i)) ||
                word_char(base + 4'(i), pos_src) != b) begin
               res.cand[i] = 1'b0;
            end
         end
      end
      // lowest live word whose length equals the position wins
      for (int i = 11; i >= 0; i--) begin
         if (4'(i) < count && cand_src[i] && word_len(base + 4'(i)) == pos_src) begin
            res.code = 4'(i + 1);
         end
      end
      res.pos = (pos_src == POS_MAX) ? POS_MAX : pos_src + 4'd1;
   end

endmodule

`default_nettype wire

// ----- sv/hrbp_parse_core.sv -----
// ---------------------------------------------------------------------------
// HTTP request byte parser core
// Parse state registers and the one-byte state update.
// ---------------------------------------------------------------------------
`default_nettype none

module hrbp_parse_core
   import hrbp_pkg::*;
#(
   parameter int LENGTH_BITS = 31
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             data_byte,
   input  logic                   restart,
   output result_type             result,
   output logic [LENGTH_BITS-1:0] body_length
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   phase_type              phase_ff, phase_in, ph;
   line_type               line_ff, line_in, ls;
   head_type               head_ff, head_in, hs;
   logic [3:0]             pos_ff, pos_in, pos;
   logic [11:0]            cand_ff, cand_in, cand;
   logic [3:0]             meth_ff, meth_in, meth;
   logic [1:0]             ver_ff, ver_in, ver;
   logic                   ka_ff, ka_in, ka;
   logic [LENGTH_BITS-1:0] len_ff, len_in, lenv;
   digit_type              dig_ff, dig_in, dig;
   logic [LENGTH_BITS-1:0] bcnt_ff, bcnt_in, bcnt;
   logic [1:0]             kk_ff, kk_in, kk;

   match_ctl_type          ctl;
   match_res_type          m;
   logic [LENGTH_BITS+3:0] prod;
   logic [LENGTH_BITS-1:0] len_sat;
   logic [2:0]             tok;
   logic                   send;
   logic                   do_key;

   // restart clears the state seen by this byte
   always_comb begin
      ph   = restart ? PH_LINE   : phase_ff;
      ls   = restart ? LS_METHOD : line_ff;
      hs   = restart ? HS_KEY    : head_ff;
      pos  = restart ? 4'd0      : pos_ff;
      cand = restart ? CAND_ALL  : cand_ff;
      meth = restart ? 4'd0      : meth_ff;
      ver  = restart ? 2'd0      : ver_ff;
      ka   = restart ? 1'b0      : ka_ff;
      lenv = restart ? '0        : len_ff;
      dig  = restart ? DG_NONE   : dig_ff;
      bcnt = restart ? '0        : bcnt_ff;
      kk   = restart ? KEY_NONE  : kk_ff;
   end

   always_comb begin
      ctl.list  = WL_METHOD;
      ctl.fresh = 1'b0;
      case (ph)
         PH_LINE: begin
            if (ls == LS_VERSION) ctl.list = WL_VERSION;
         end
         PH_HEAD: begin
            case (hs)
               HS_NEXT:              begin ctl.list = WL_KEY; ctl.fresh = 1'b1; end
               HS_VAL_FIRST, HS_VAL: ctl.list = WL_VALUE;
               default:              ctl.list = WL_KEY;
            endcase
         end
         default: ;
      endcase
   end

   hrbp_word_match u_match (
      .ctl       (ctl),
      .cand      (cand),
      .pos       (pos),
      .data_byte (data_byte),
      .res       (m)
   );

   // length * 10 + digit, saturating
   assign prod = ({4'b0, lenv} << 3) + ({4'b0, lenv} << 1) +
                 (LENGTH_BITS+4)'(data_byte[3:0]);
   assign len_sat = (prod > {4'b0, LEN_MAX}) ? LEN_MAX : prod[LENGTH_BITS-1:0];

   always_comb begin
      phase_in = ph;
      line_in  = ls;
      head_in  = hs;
      pos_in   = pos;
      cand_in  = cand;
      meth_in  = meth;
      ver_in   = ver;
      ka_in    = ka;
      len_in   = lenv;
      dig_in   = dig;
      bcnt_in  = bcnt;
      kk_in    = kk;
      tok      = TOK_NONE;
      send     = 1'b0;
      do_key   = 1'b0;

      case (ph)
         PH_LINE: begin
            case (ls)
               LS_METHOD: begin
                  if (data_byte == CH_SP) begin
                     meth_in = m.code;
                     line_in = LS_URL;
                  end else begin
                     cand_in = m.cand;
                     pos_in  = m.pos;
                     tok     = TOK_METHOD;
                  end
               end
               LS_URL: begin
                  if (data_byte == CH_SP) begin
                     cand_in = CAND_ALL;
                     pos_in  = 4'd0;
                     line_in = LS_VERSION;
                  end else begin
                     tok = TOK_URL;
                  end
               end
               LS_VERSION: begin
                  if (data_byte == CH_CR) begin
                     ver_in  = m.code[1:0];
                     if (m.code == VER_11) ka_in = 1'b1;
                     line_in = LS_LF;
                  end else begin
                     cand_in = m.cand;
                     pos_in  = m.pos;
                     tok     = TOK_VERSION;
                  end
               end
               default: begin
                  if (data_byte == CH_LF) begin
                     phase_in = PH_HEAD;
                     head_in  = HS_KEY;
                     cand_in  = CAND_ALL;
                     pos_in   = 4'd0;
                     send     = 1'b1;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
            endcase
         end
         PH_HEAD: begin
            case (hs)
               HS_KEY: do_key = 1'b1;
               HS_COLON: begin
                  if (data_byte == CH_SP) begin
                     cand_in = CAND_ALL;
                     pos_in  = 4'd0;
                     if (kk == KEY_CLEN) begin
                        len_in = '0;
                        dig_in = DG_NONE;
                     end
                     head_in = HS_VAL_FIRST;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               HS_VAL_FIRST, HS_VAL: begin
                  head_in = HS_VAL;
                  if (data_byte == CH_CR) begin
                     if (kk == KEY_CLEN && (dig == DG_NONE || dig == DG_BAD)) begin
                        phase_in = PH_ERR;
                     end else if (kk == KEY_CONN && m.code == VAL_KEEP) begin
                        ka_in = 1'b1;
                     end
                     head_in = HS_CR;
                  end else begin
                     cand_in = m.cand;
                     pos_in  = m.pos;
                     tok     = TOK_VALUE;
                     if (kk == KEY_CLEN) begin
                        if (data_byte inside {[CH_0:CH_9]}) begin
                           if (dig == DG_NONE || dig == DG_DIGITS) begin
                              len_in = len_sat;
                              dig_in = DG_DIGITS;
                           end
                        end else if (dig == DG_NONE) begin
                           if (data_byte != CH_SP && data_byte != CH_TAB) dig_in = DG_BAD;
                        end else if (dig == DG_DIGITS) begin
                           dig_in = DG_DONE;
                        end
                     end
                  end
               end
               HS_CR: begin
                  if (data_byte == CH_LF) head_in = HS_NEXT;
                  else                    phase_in = PH_ERR;
               end
               HS_NEXT: begin
                  if (data_byte == CH_CR) begin
                     head_in = HS_END;
                  end else begin
                     // a new key starts on this byte
                     cand_in = CAND_ALL;
                     pos_in  = 4'd0;
                     head_in = HS_KEY;
                     do_key  = 1'b1;
                  end
               end
               default: begin
                  if (data_byte == CH_LF) begin
                     phase_in = (lenv != '0) ? PH_BODY : PH_DONE;
                     bcnt_in  = '0;
                     send     = 1'b1;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
            endcase
         end
         PH_BODY: begin
            tok     = TOK_BODY;
            bcnt_in = bcnt + LENGTH_BITS'(1);
            if (bcnt_in == lenv) begin
               phase_in = PH_DONE;
               send     = 1'b1;
            end
         end
         default: ;
      endcase

      if (do_key) begin
         if (data_byte == CH_COLON) begin
            kk_in   = m.code[1:0];
            head_in = HS_COLON;
         end else if (data_byte == CH_CR || data_byte == CH_LF) begin
            phase_in = PH_ERR;
         end else begin
            cand_in = m.cand;
            pos_in  = m.pos;
            tok     = TOK_KEY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE;
         line_ff  <= LS_METHOD;
         head_ff  <= HS_KEY;
         pos_ff   <= 4'd0;
         cand_ff  <= CAND_ALL;
         meth_ff  <= 4'd0;
         ver_ff   <= 2'd0;
         ka_ff    <= 1'b0;
         len_ff   <= '0;
         dig_ff   <= DG_NONE;
         bcnt_ff  <= '0;
         kk_ff    <= KEY_NONE;
      end else if (advance) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         head_ff  <= head_in;
         pos_ff   <= pos_in;
         cand_ff  <= cand_in;
         meth_ff  <= meth_in;
         ver_ff   <= ver_in;
         ka_ff    <= ka_in;
         len_ff   <= len_in;
         dig_ff   <= dig_in;
         bcnt_ff  <= bcnt_in;
         kk_ff    <= kk_in;
      end
   end

   always_comb begin
      result.byte_echo    = data_byte;
      result.token_kind   = tok;
      result.parse_phase  = phase_code(phase_in);
      result.method_code  = meth_in;
      result.version_code = ver_in;
      result.keep_alive   = ka_in;
      result.section_end  = send;
   end

   assign body_length = len_in;

endmodule

`default_nettype wire

// ----- sv/http_request_byte_parser.sv -----
// ---------------------------------------------------------------------------
// HTTP request byte parser
// Tags each request byte with its token kind and tracks request framing.
// ---------------------------------------------------------------------------
// One request byte enters per word on the req_ side and one tagged result
// word leaves on the rsp_ side for every byte, in order. The block sustains
// one byte per clock cycle unless rsp_ stalls; a byte's result passes
// through the input register, then the result register, before it is
// presented on rsp_, and that one-byte rate rests on the parse state (phase,
// step, word candidates, length and counters) updated once per byte. The
// input register keeps taking bytes while a result waits on a stalled rsp_
// side, until both registers are full. Set req_tuser (restart) on the first
// byte of a new request to clear all parse state, keep-alive included, before
// that byte is handled. Finished and error phases are sticky until restart;
// bytes there are echoed with token kind zero. rsp_tlast marks the LF ending
// the request line or the header block, and the last body byte.
`default_nettype none

module http_request_byte_parser
   import hrbp_pkg::*;
#(
   parameter int LENGTH_BITS = 31
)(
   input  logic clock,
   input  logic reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [0:0] req_tuser,   // [0] restart

   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [7:0] byte_echo, [10:8] parse_phase, [14:11] method_code,
   // [16:15] version_code, [17] keep_alive, [17+LENGTH_BITS:18] body_length
   output logic [((18+LENGTH_BITS+7)/8)*8-1:0]      rsp_tdata,
   output logic [2:0]                              rsp_tuser,   // [2:0] token_kind
   output logic                                    rsp_tlast    // section_end
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_data_ff;
   logic                   in_restart_ff;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_res_ff, res;
   logic [LENGTH_BITS-1:0] out_len_ff, res_len;
   logic                   advance;

   // move the held byte into the result register when that slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)         out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold input payload on accept only, result payload on advance only
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff    <= req_tdata;
         in_restart_ff <= req_tuser[0];
      end
      if (advance) begin
         out_res_ff <= res;
         out_len_ff <= res_len;
      end
   end

   hrbp_parse_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_data_ff),
      .restart     (in_restart_ff),
      .result      (res),
      .body_length (res_len)
   );

   // pack result fields, pad bits stay zero
   always_comb begin
      rsp_tdata                    = '0;
      rsp_tdata[7:0]               = out_res_ff.byte_echo;
      rsp_tdata[10:8]              = out_res_ff.parse_phase;
      rsp_tdata[14:11]             = out_res_ff.method_code;
      rsp_tdata[16:15]             = out_res_ff.version_code;
      rsp_tdata[17]                = out_res_ff.keep_alive;
      rsp_tdata[18 +: LENGTH_BITS] = out_len_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.token_kind;
   assign rsp_tlast  = out_res_ff.section_end;

endmodule

`default_nettype wire
